// ----- design/lzwvd_pkg.sv -----
// Shared types and constants for the variable-width LZW decoder.
// No dependencies; every other design file imports this package.
package lzwvd_pkg;

   // Configuration defaults for the top-level parameters
   localparam int MIN_WIDTH         = 9;
   localparam int DEF_MAX_WIDTH     = 15;
   localparam int DEF_DICT_DEPTH    = 32768;
   localparam int DEF_COUNT_WIDTH   = 32;
   localparam int QUEUE_DEPTH       = 2;

   // Control codes
   localparam int CODE_END   = 256;
   localparam int CODE_BUMP  = 257;
   localparam int CODE_CLEAR = 258;
   localparam int CODE_FIRST = 259;
   localparam int LITERAL_MAX = 255;

   // Result status codes
   typedef logic [2:0] status_type;
   localparam status_type ST_BYTE     = 3'd0;
   localparam status_type ST_ACCEPTED = 3'd1;
   localparam status_type ST_NEED     = 3'd2;
   localparam status_type ST_DONE     = 3'd3;
   localparam status_type ST_REFUSED  = 3'd4;
   localparam status_type ST_TRUNC    = 3'd5;
   localparam status_type ST_BAD      = 3'd6;
   localparam status_type ST_OVER     = 3'd7;

   // Decoder phases; terminal phases reuse their status codes
   localparam status_type PH_OPEN = 3'd0;
   localparam status_type PH_RUN  = 3'd1;

   // Request operations
   localparam logic OP_FEED  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_STRICT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT  = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data;
      logic [31:0] produced;
      logic [31:0] consumed;
   } rsp_type;

   typedef struct packed {
      logic        strict;
      logic [31:0] limit;
   } cfg_type;

endpackage

// ----- design/lzwvd_fifo.sv -----
// Small register-based queue used between front, engine and result side.
// Depends on lzwvd_pkg for the default depth.
module lzwvd_fifo import lzwvd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, rptr_ff;
   logic [CNTW-1:0]  count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         if (do_pop)  rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= wdata;
   end

endmodule

// ----- design/lzwvd_engine.sv -----
// Back end of the decoder: bit unpacking, code handling, dictionary walk
// and output stack. Depends on lzwvd_pkg.
module lzwvd_engine import lzwvd_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);
   localparam int CW = MAX_WIDTH;
   localparam int AW = $clog2(DICT_DEPTH);
   localparam int NW = AW + 1;
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int KW = COUNT_WIDTH;
   localparam int XW = ((CW > NW) ? CW : NW) + 2;
   localparam int LW = ((KW > 32) ? KW : 32) + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_POP, S_CODE, S_WALK_RD, S_WALK_DATA, S_FINISH
   } state_type;

   state_type      state_ff;
   status_type     phase_ff;
   logic [7:0]     buffer_ff;
   logic [3:0]     rem_ff;
   logic           last_ff;
   logic [CW-1:0]  accum_ff;
   logic [SW-1:0]  abits_ff;
   logic [SW-1:0]  cwidth_ff;
   logic [NW-1:0]  nfc_ff;
   logic [NW-1:0]  hwm_ff;
   logic [CW-1:0]  prior_ff;
   logic [7:0]     first_ff;
   logic [KW-1:0]  out_total_ff;
   logic [KW-1:0]  in_total_ff;
   logic [NW-1:0]  sdepth_ff;
   logic [NW-1:0]  depth_ff;
   logic [CW-1:0]  walk_ff;
   logic [CW-1:0]  code_ff;
   logic           push_ff;
   rsp_type        rsp_ff;

   // memories
   logic [7:0]     stack_mem [DICT_DEPTH];
   logic [CW+7:0]  dict_mem  [DICT_DEPTH];
   logic [7:0]     st_rdata_ff;
   logic [CW+7:0]  dict_rdata_ff;
   logic           dict_hit_ff;
   logic           st_we, dict_we;
   logic [AW-1:0]  st_waddr, st_raddr, dict_waddr, dict_raddr;
   logic [7:0]     st_wdata;
   logic [CW+7:0]  dict_wdata;

   // unpacking helpers
   logic [SW-1:0]  want, need, rem_w, take;
   logic [CW+7:0]  shifted;
   logic [CW-1:0]  accum_in;
   logic [7:0]     buffer_in;

   // compare helpers
   logic [XW-1:0]  code_x, nfc_x, walk_x, dict_x, depth_x, cap_x, hwm_x;
   logic [LW-1:0]  out_l, lim_l, sum_l;
   logic           open_ok, run_bad, kwk, walk_big, walk_bad, over;
   logic [31:0]    produced_now, consumed_now;

   // bit unpacking: take as many bits as the buffer offers toward the code
   always_comb begin
      want      = (phase_ff == PH_OPEN) ? SW'(MIN_WIDTH) : cwidth_ff;
      need      = want - abits_ff;
      rem_w     = SW'(rem_ff);
      take      = (need < rem_w) ? need : rem_w;
      shifted   = {accum_ff, buffer_ff} << take;
      accum_in  = shifted[CW+7:8];
      buffer_in = shifted[7:0];
   end

   // code classification
   always_comb begin
      code_x   = XW'(code_ff);
      nfc_x    = XW'(nfc_ff);
      walk_x   = XW'(walk_ff);
      dict_x   = XW'(DICT_DEPTH);
      depth_x  = XW'(depth_ff);
      hwm_x    = XW'(hwm_ff);
      cap_x    = XW'(1) << cwidth_ff;
      out_l    = LW'(out_total_ff);
      lim_l    = LW'(cfg.limit);
      sum_l    = out_l + LW'(depth_ff);
      open_ok  = (code_x != XW'(CODE_END)) && !(cfg.strict && code_x > XW'(LITERAL_MAX))
                 && !(out_l >= lim_l);
      run_bad  = cfg.strict && ((code_x > nfc_x) || (nfc_x > cap_x));
      kwk      = (code_x >= nfc_x);
      walk_big = (walk_x > XW'(LITERAL_MAX));
      walk_bad = (walk_x >= dict_x) || (depth_x >= dict_x);
      over     = (sum_l > lim_l);
      produced_now = 32'(out_total_ff - KW'(sdepth_ff));
      consumed_now = 32'(in_total_ff);
   end

   // memory port control
   always_comb begin
      st_we      = 1'b0;
      st_waddr   = AW'(depth_ff);
      st_wdata   = walk_ff[7:0];
      dict_we    = 1'b0;
      dict_waddr = AW'(nfc_ff);
      dict_wdata = {prior_ff, first_ff};
      st_raddr   = AW'(sdepth_ff - 1'b1);
      dict_raddr = AW'(walk_ff);
      unique case (state_ff)
         S_CODE: begin
            if (phase_ff == PH_OPEN) begin
               st_we    = open_ok;
               st_waddr = '0;
               st_wdata = code_ff[7:0];
            end else begin
               st_we    = (code_x != XW'(CODE_END)) && (code_x != XW'(CODE_BUMP))
                          && (code_x != XW'(CODE_CLEAR)) && !run_bad && kwk;
               st_waddr = '0;
               st_wdata = first_ff;
            end
         end
         S_WALK_RD: begin
            st_we = !walk_big && (depth_x < dict_x);
         end
         S_WALK_DATA: begin
            st_we    = 1'b1;
            st_wdata = dict_hit_ff ? dict_rdata_ff[7:0] : 8'd0;
         end
         S_FINISH: begin
            dict_we = !over && (nfc_x < dict_x);
         end
         default: begin
         end
      endcase
   end

   // output stack
   always_ff @(posedge clock) begin
      if (st_we) stack_mem[st_waddr] <= st_wdata;
      st_rdata_ff <= stack_mem[st_raddr];
   end

   // dictionary; entries outside the written range read as zero
   always_ff @(posedge clock) begin
      if (dict_we) dict_mem[dict_waddr] <= dict_wdata;
      dict_rdata_ff <= dict_mem[dict_raddr];
      dict_hit_ff   <= (walk_x >= XW'(CODE_FIRST)) && (walk_x < hwm_x);
   end

   assign cmd_pop  = (state_ff == S_IDLE) && !cmd_empty && !push_ff && !rsp_full;
   assign rsp_push = push_ff;
   assign rsp      = rsp_ff;

   // sequencer; push_ff is only ever high for one cycle in S_IDLE
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_OPEN;
         buffer_ff    <= '0;
         rem_ff       <= '0;
         last_ff      <= 1'b0;
         accum_ff     <= '0;
         abits_ff     <= '0;
         cwidth_ff    <= SW'(MIN_WIDTH);
         nfc_ff       <= NW'(CODE_FIRST);
         hwm_ff       <= NW'(CODE_FIRST);
         prior_ff     <= '0;
         first_ff     <= '0;
         out_total_ff <= '0;
         in_total_ff  <= '0;
         sdepth_ff    <= '0;
         push_ff      <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  if (cmd.operation == OP_FETCH) begin
                     state_ff <= S_FETCH;
                  end else begin
                     push_ff <= 1'b1;
                     if ((phase_ff == PH_OPEN || phase_ff == PH_RUN) && rem_ff == 4'd0
                         && !last_ff) begin
                        buffer_ff <= cmd.data;
                        rem_ff    <= 4'd8;
                        last_ff   <= cmd.last;
                        rsp_ff    <= '{ST_ACCEPTED, 8'd0, produced_now, consumed_now};
                     end else begin
                        rsp_ff    <= '{ST_REFUSED, 8'd0, produced_now, consumed_now};
                     end
                  end
               end else begin
                  push_ff <= 1'b0;
               end
            end
            S_FETCH: begin
               priority if (sdepth_ff != '0) begin
                  sdepth_ff <= sdepth_ff - 1'b1;
                  state_ff  <= S_POP;
               end else if (phase_ff != PH_OPEN && phase_ff != PH_RUN) begin
                  push_ff  <= 1'b1;
                  rsp_ff   <= '{phase_ff, 8'd0, produced_now, consumed_now};
                  state_ff <= S_IDLE;
               end else if (rem_ff == 4'd0) begin
                  push_ff  <= 1'b1;
                  state_ff <= S_IDLE;
                  if (last_ff) begin
                     phase_ff <= ST_TRUNC;
                     rsp_ff   <= '{ST_TRUNC, 8'd0, produced_now, consumed_now};
                  end else begin
                     rsp_ff   <= '{ST_NEED, 8'd0, produced_now, consumed_now};
                  end
               end else begin
                  buffer_ff <= buffer_in;
                  rem_ff    <= rem_ff - 4'(take);
                  if (rem_ff == 4'd8) in_total_ff <= in_total_ff + 1'b1;
                  if (abits_ff + take == want) begin
                     code_ff  <= accum_in;
                     accum_ff <= '0;
                     abits_ff <= '0;
                     state_ff <= S_CODE;
                  end else begin
                     accum_ff <= accum_in;
                     abits_ff <= abits_ff + take;
                  end
               end
            end
            S_POP: begin
               push_ff  <= 1'b1;
               rsp_ff   <= '{ST_BYTE, st_rdata_ff, produced_now, consumed_now};
               state_ff <= S_IDLE;
            end
            S_CODE: begin
               state_ff <= S_FETCH;
               if (phase_ff == PH_OPEN) begin
                  priority if (code_x == XW'(CODE_END)) begin
                     phase_ff <= ST_DONE;
                  end else if (cfg.strict && code_x > XW'(LITERAL_MAX)) begin
                     phase_ff <= ST_BAD;
                  end else if (out_l >= lim_l) begin
                     phase_ff <= ST_OVER;
                  end else begin
                     sdepth_ff    <= NW'(1);
                     out_total_ff <= out_total_ff + 1'b1;
                     nfc_ff       <= NW'(CODE_FIRST);
                     cwidth_ff    <= SW'(MIN_WIDTH);
                     prior_ff     <= code_ff;
                     first_ff     <= code_ff[7:0];
                     phase_ff     <= PH_RUN;
                  end
               end else begin
                  priority if (code_x == XW'(CODE_END)) begin
                     phase_ff <= ST_DONE;
                  end else if (code_x == XW'(CODE_BUMP)) begin
                     if (cfg.strict && cwidth_ff >= SW'(MAX_WIDTH)) phase_ff <= ST_BAD;
                     else if (cwidth_ff < SW'(MAX_WIDTH)) cwidth_ff <= cwidth_ff + 1'b1;
                  end else if (code_x == XW'(CODE_CLEAR)) begin
                     phase_ff <= PH_OPEN;
                  end else if (run_bad) begin
                     phase_ff <= ST_BAD;
                  end else begin
                     // code not yet in the table: repeat the first character
                     if (kwk) begin
                        depth_ff <= NW'(1);
                        walk_ff  <= prior_ff;
                     end else begin
                        depth_ff <= '0;
                        walk_ff  <= code_ff;
                     end
                     state_ff <= S_WALK_RD;
                  end
               end
            end
            S_WALK_RD: begin
               priority if (walk_big) begin
                  if (walk_bad) begin
                     phase_ff <= ST_BAD;
                     state_ff <= S_FETCH;
                  end else begin
                     state_ff <= S_WALK_DATA;
                  end
               end else if (depth_x >= dict_x) begin
                  phase_ff <= ST_BAD;
                  state_ff <= S_FETCH;
               end else begin
                  first_ff <= walk_ff[7:0];
                  depth_ff <= depth_ff + 1'b1;
                  state_ff <= S_FINISH;
               end
            end
            S_WALK_DATA: begin
               depth_ff <= depth_ff + 1'b1;
               walk_ff  <= dict_hit_ff ? dict_rdata_ff[CW+7:8] : '0;
               state_ff <= S_WALK_RD;
            end
            S_FINISH: begin
               state_ff <= S_FETCH;
               if (over) begin
                  phase_ff <= ST_OVER;
               end else begin
                  out_total_ff <= out_total_ff + KW'(depth_ff);
                  sdepth_ff    <= depth_ff;
                  prior_ff     <= code_ff;
                  if (nfc_x < dict_x) begin
                     nfc_ff <= nfc_ff + 1'b1;
                     if (nfc_ff + 1'b1 > hwm_ff) hwm_ff <= nfc_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- design/lzw_variable_width_decoder.sv -----
// Top level of the variable-width LZW decoder: request queue, engine,
// result queue and the configuration registers. Depends on lzwvd_pkg.
//
//  channel  ports                        handshake
//  request  req_operation/data_in/last   req_push, req_full
//  result   rsp_status/data_out/counts   rsp_empty, rsp_pop
//  config   csr_index, csr_data          csr_valid, csr_ready (always 1)
//
// A feed request is answered straight from the idle state; a fetch that pops a
// pending byte goes through the fetch and pop states. Decoding a code adds the
// last-bits and classify states, a read and a data state per dictionary character
// walked (one registered read each) and a finish state; a control code adds only the first.
// Reset is synchronous and needs no clearing pass: dictionary entries above
// a high-water mark read as zero. A full result queue stalls the engine.
module lzw_variable_width_decoder import lzwvd_pkg::*; #(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int DICT_DEPTH  = DEF_DICT_DEPTH,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_operation,
   input  logic [7:0]             req_data_in,
   input  logic                   req_input_last,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_data_out,
   output logic [31:0]            rsp_produced_count,
   output logic [31:0]            rsp_consumed_count,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);
   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cfg_type cfg_ff;
   cmd_type req_cmd, cmd_head;
   rsp_type eng_rsp, rsp_head;
   logic    cmd_empty, cmd_pop, eng_push, rsp_q_full;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strict <= 1'b0;
         cfg_ff.limit  <= 32'hFFFF_FFFF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_STRICT: cfg_ff.strict <= csr_data[0];
            REG_LIMIT:  cfg_ff.limit  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // front: request queue
   assign req_cmd = '{req_operation, req_data_in, req_input_last};

   lzwvd_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_cmd),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_head),
      .empty (cmd_empty)
   );

   // back: decode engine
   lzwvd_engine #(
      .MAX_WIDTH   (MAX_WIDTH),
      .DICT_DEPTH  (DICT_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (eng_push),
      .rsp       (eng_rsp)
   );

   // result queue
   lzwvd_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (eng_push),
      .wdata (eng_rsp),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_status         = rsp_head.status;
   assign rsp_data_out       = rsp_head.data;
   assign rsp_produced_count = rsp_head.produced;
   assign rsp_consumed_count = rsp_head.consumed;

   // engine never pushes into a full result queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(eng_push && rsp_q_full)) else $error("result pushed into full queue");

   // engine only takes requests that exist
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      !(cmd_pop && cmd_empty)) else $error("request popped from empty queue");

   // data is zero unless a byte is returned
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_BYTE) |-> (rsp_data_out == 8'd0))
      else $error("nonzero data on non-byte result");

endmodule

// ----- bench/lzw_variable_width_decoder_tb.sv -----
// Self-checking bench for the variable-width LZW decoder: an LZW encoder builds
// streams, a cycle-free decoder model predicts every result. Depends on lzwvd_pkg.
`timescale 1ns / 100ps

module lzw_variable_width_decoder_tb import lzwvd_pkg::*; ();

   localparam int DEPTH     = DEF_DICT_DEPTH;
   localparam int MAXW      = DEF_MAX_WIDTH;
   localparam int STALL_MAX = 150000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_operation = OP_FEED;
   logic [7:0]  req_data_in = 8'd0;
   logic        req_input_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_data_out;
   logic [31:0] rsp_produced_count;
   logic [31:0] rsp_consumed_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_STRICT;
   logic [31:0] csr_data = 32'd0;

   lzw_variable_width_decoder dut (.*);

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- decoder model ----------------
   logic        m_strict;
   logic [31:0] m_limit;
   logic [14:0] m_prefix [DEPTH];
   logic [7:0]  m_suffix [DEPTH];
   logic [7:0]  m_stack  [DEPTH];
   int unsigned m_sp, m_bits_left, m_accum, m_accum_bits, m_width, m_next;
   int unsigned m_prior, m_first;
   status_type  m_phase;
   logic [31:0] m_out_total, m_in_total;
   logic [7:0]  m_buf;
   bit          m_last_fed;

   task automatic model_reset();
      for (int i = 0; i < DEPTH; i++) begin
         m_prefix[i] = '0;
         m_suffix[i] = '0;
      end
      m_strict = 1'b0; m_limit = 32'hFFFF_FFFF;
      m_sp = 0; m_buf = '0; m_bits_left = 0; m_accum = 0; m_accum_bits = 0;
      m_width = MIN_WIDTH; m_next = CODE_FIRST; m_prior = 0; m_first = 0;
      m_phase = PH_OPEN; m_out_total = '0; m_in_total = '0; m_last_fed = 0;
   endtask

   task automatic model_code(input int unsigned code);
      int unsigned d, walk;
      longint unsigned room;
      d = 0;
      if (m_phase == PH_OPEN) begin
         if (code == CODE_END) begin m_phase = ST_DONE; return; end
         if (m_strict && code > LITERAL_MAX) begin m_phase = ST_BAD; return; end
         if (m_out_total >= m_limit) begin m_phase = ST_OVER; return; end
         m_stack[0] = code[7:0]; m_sp = 1; m_out_total++;
         m_next = CODE_FIRST; m_width = MIN_WIDTH; m_prior = code;
         m_first = code & 8'hFF; m_phase = PH_RUN;
         return;
      end
      if (code == CODE_END) begin m_phase = ST_DONE; return; end
      if (code == CODE_BUMP) begin
         if (m_strict && m_width >= MAXW) begin m_phase = ST_BAD; return; end
         if (m_width < MAXW) m_width++;
         return;
      end
      if (code == CODE_CLEAR) begin m_phase = PH_OPEN; return; end
      if (m_strict && (code > m_next || m_next > (1 << m_width))) begin
         m_phase = ST_BAD; return;
      end
      if (code >= m_next) begin
         m_stack[d++] = m_first[7:0]; walk = m_prior;
      end else walk = code;
      while (walk > LITERAL_MAX) begin
         if (walk >= DEPTH || d >= DEPTH) begin m_phase = ST_BAD; return; end
         m_stack[d++] = m_suffix[walk]; walk = m_prefix[walk];
      end
      if (d >= DEPTH) begin m_phase = ST_BAD; return; end
      m_stack[d++] = walk[7:0]; m_first = walk & 8'hFF;
      room = longint'(m_limit) - longint'(m_out_total);
      if (m_out_total > m_limit || d > room) begin m_phase = ST_OVER; return; end
      m_out_total += d; m_sp = d;
      if (m_next < DEPTH) begin
         m_prefix[m_next] = m_prior[14:0]; m_suffix[m_next] = m_first[7:0]; m_next++;
      end
      m_prior = code;
   endtask

   task automatic model_fetch(output status_type st, output logic [7:0] b);
      int unsigned w, code;
      b = '0;
      forever begin
         if (m_sp > 0) begin m_sp--; b = m_stack[m_sp]; st = ST_BYTE; return; end
         if (m_phase != PH_OPEN && m_phase != PH_RUN) begin st = m_phase; return; end
         w = (m_phase == PH_OPEN) ? MIN_WIDTH : m_width;
         while (m_accum_bits < w) begin
            if (m_bits_left == 0) begin
               if (m_last_fed) begin m_phase = ST_TRUNC; st = ST_TRUNC; end
               else st = ST_NEED;
               return;
            end
            if (m_bits_left == 8) m_in_total++;
            m_accum = ((m_accum << 1) | m_buf[7]) & 16'hFFFF;
            m_buf = m_buf << 1; m_bits_left--; m_accum_bits++;
         end
         code = m_accum; m_accum = 0; m_accum_bits = 0;
         model_code(code);
      end
   endtask

   task automatic model_request(input cmd_type c, output rsp_type r);
      status_type st;
      logic [7:0] b;
      b = '0;
      if (c.operation == OP_FEED) begin
         if ((m_phase == PH_OPEN || m_phase == PH_RUN) && m_bits_left == 0
             && !m_last_fed) begin
            m_buf = c.data; m_bits_left = 8; m_last_fed = c.last; st = ST_ACCEPTED;
         end else st = ST_REFUSED;
      end else model_fetch(st, b);
      r.status = st; r.data = (st == ST_BYTE) ? b : 8'd0;
      r.produced = m_out_total - m_sp; r.consumed = m_in_total;
   endtask

   // ---------------- stream builder (LZW encoder) ----------------
   cmd_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   bit          stream_bits[$];
   int unsigned enc_dict [int unsigned];   // key {prefix,char} -> code

   task automatic put_code(input int unsigned code, input int unsigned w);
      for (int i = w - 1; i >= 0; i--) stream_bits.push_back(code[i]);
   endtask

   // Pack bits into feeds; interleave fetches so the stream is drained.
   task automatic emit_stream(input bit with_last, input int extra_fetch);
      cmd_type c;
      while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'($urandom_range(0, 1)));
      while (stream_bits.size() > 0) begin
         c.operation = OP_FEED; c.data = '0;
         for (int i = 0; i < 8; i++) c.data = {c.data[6:0], stream_bits.pop_front()};
         c.last = with_last && stream_bits.size() == 0;
         if ($urandom_range(0, 19) == 0) c.last = ~c.last | !with_last ? c.last : c.last;
         pending_reqs.push_back(c);
         repeat ($urandom_range(1, 3)) begin
            c.operation = OP_FETCH; c.data = 8'($urandom); c.last = 1'($urandom);
            pending_reqs.push_back(c);
         end
      end
      repeat (extra_fetch) begin
         c.operation = OP_FETCH; c.data = 8'($urandom); c.last = 1'($urandom);
         pending_reqs.push_back(c);
      end
   endtask

   // Encode random text with real LZW; widths follow via BUMP codes.
   task automatic build_stream(input int n_chars, input int alpha, input bit bumps,
                               input bit with_clear);
      int unsigned w, nxt, cur, ch, key;
      w = MIN_WIDTH; nxt = CODE_FIRST; enc_dict.delete();
      cur = $urandom_range(0, alpha);
      for (int i = 1; i < n_chars; i++) begin
         ch = $urandom_range(0, alpha);
         key = (cur << 8) | ch;
         if (enc_dict.exists(key)) cur = enc_dict[key];
         else begin
            put_code(cur, w);
            if (nxt < DEPTH) begin enc_dict[key] = nxt; nxt++; end
            if (bumps && nxt >= (1 << w) && w < MAXW) begin
               put_code(CODE_BUMP, w); w++;
            end
            cur = ch;
         end
      end
      put_code(cur, w);
      if (with_clear) begin
         // clear keeps the dictionary; restart with a literal
         put_code(CODE_CLEAR, w);
         put_code($urandom_range(0, 255), MIN_WIDTH);
         w = MIN_WIDTH;
      end
      put_code(CODE_END, w);
   endtask

   task automatic raw_code(input int unsigned code, input int unsigned w);
      put_code(code, w);
   endtask

   // ---------------- csr and flow control ----------------
   int    send_idle_pct = 0, pop_stall_pct = 0;
   bit    hold_send = 0;
   int    idle_count = 0;
   bit    failed = 0;

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_STRICT) m_strict = val[0];
      else m_limit = val;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // driver: the head of pending_reqs is what is on the ports until taken
   always @(posedge clock) begin
      rsp_type r;
      cmd_type c;
      if (!reset) begin
         if (req_push && !req_full) begin
            model_request('{req_operation, req_data_in, req_input_last}, r);
            expected_rsps.push_back(r);
            void'(pending_reqs.pop_front());
         end
         // a request that waits on full stays on the ports unchanged
         if (!(req_push && req_full)) begin
            if (pending_reqs.size() > 0 && !hold_send &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               c = pending_reqs[0];
               req_push <= 1'b1; req_operation <= c.operation;
               req_data_in <= c.data; req_input_last <= c.last;
            end else req_push <= 1'b0;
         end
      end
   end

   // monitor: check popped results
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $error("result with nothing expected"); failed = 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); failed = 1;
               end
               if (rsp_data_out !== e.data) begin
                  $error("data_out exp %0h got %0h", e.data, rsp_data_out); failed = 1;
               end
               if (rsp_produced_count !== e.produced) begin
                  $error("produced_count exp %0d got %0d", e.produced,
                         rsp_produced_count); failed = 1;
               end
               if (rsp_consumed_count !== e.consumed) begin
                  $error("consumed_count exp %0d got %0d", e.consumed,
                         rsp_consumed_count); failed = 1;
               end
            end
         end
         rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_count = 0;
         else idle_count++;
         if (idle_count >= STALL_MAX) begin
            $display("== FAIL =="); $finish;
         end
      end
   end

   // one stream: reset model stream state is carried across; end with fetches
   task automatic run_stream(input int n, input int alpha, input bit bumps,
                             input bit clr, input bit last_flag);
      build_stream(n, alpha, bumps, clr);
      emit_stream(last_flag, 4);
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: fetch before data, then a small clean stream
      write_reg(REG_STRICT, 1'b0);
      write_reg(REG_LIMIT, 32'hFFFF_FFFF);
      begin
         cmd_type c;
         c = '{OP_FETCH, 8'hFF, 1'b1}; pending_reqs.push_back(c);
      end
      run_stream(40, 3, 1, 1, 1);
      // feeds after done are refused
      begin
         cmd_type c;
         c = '{OP_FEED, 8'h00, 1'b0}; pending_reqs.push_back(c);
         c = '{OP_FEED, 8'hFF, 1'b1}; pending_reqs.push_back(c);
      end
      hold_send = 0;
      drain();

      // the remaining directed cases share one phase each, needing fresh state.
      // The decoder cannot be reset again, so later streams rely on the
      // terminal state: only the first stream decodes; the rest check sticky
      // status, feeds refused and counters.
      write_reg(REG_STRICT, 1'b1);
      write_reg(REG_LIMIT, 32'd1);
      for (int i = 0; i < 20; i++) begin
         cmd_type c;
         c.operation = 1'($urandom); c.data = 8'($urandom); c.last = 1'($urandom);
         pending_reqs.push_back(c);
      end
      drain();

      // random phases over the flow-control settings
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 51 : 31) : 0;
         pop_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 51 : 31) : 0;
         write_reg(REG_STRICT, ph[0]);
         write_reg(REG_LIMIT, (ph == 2) ? 32'd0 : $urandom);
         for (int i = 0; i < 270; i++) begin
            cmd_type c;
            c.operation = 1'($urandom); c.data = 8'($urandom); c.last = 1'($urandom);
            pending_reqs.push_back(c);
         end
         hold_send = 1;
         repeat (5) @(posedge clock);
         hold_send = 0;
         drain();
      end

      if (!failed) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- sim.f -----
design/lzwvd_pkg.sv
design/lzwvd_fifo.sv
design/lzwvd_engine.sv
design/lzw_variable_width_decoder.sv
bench/lzw_variable_width_decoder_tb.sv
